@@ rtl/fmpd_pkg.sv @@
// ----------------------------------------------------------------------------
// FM phase discriminator package
// Shared types, CORDIC widths and the arctangent table.
// ----------------------------------------------------------------------------
package fmpd_pkg;

   // CORDIC datapath: vectors normalized so the top set bit sits at NORM_TOP
   localparam int CORDIC_WIDTH = 63;
   localparam int ANGLE_WIDTH  = 33;
   localparam int CORDIC_STEPS = 30;
   localparam int NORM_TOP     = 58;
   localparam int SHIFT_WIDTH  = 6;

   // quarter turn in units of pi/2^31
   localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_QUARTER = 33'sd1073741824;

   // atan(2^-i) in units of pi/2^31, rounded to nearest
   localparam logic signed [ANGLE_WIDTH-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
      33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
      33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
      33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
      33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
      33'sd652,       33'sd326,       33'sd163,       33'sd81,
      33'sd41,        33'sd20,        33'sd10,        33'sd5,
      33'sd3,         33'sd1
   };

   // per-stage control that travels with each request
   typedef struct packed {
      logic valid;
      logic last;
      logic zero;
   } ctl_type;

endpackage

@@ rtl/fmpd_norm.sv @@
// ----------------------------------------------------------------------------
// FM phase discriminator normalizer
// Three-stage left shift that moves the leading one of max(|x|,|y|) to
// bit NORM_TOP: leading-one search, coarse shift in steps of 8, fine shift.
// ----------------------------------------------------------------------------
module fmpd_norm
   import fmpd_pkg::*;
#(
   parameter int IN_WIDTH = 33
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  ctl_type                        ctl_prev,
   input  logic signed [IN_WIDTH-1:0]     x_prev,
   input  logic signed [IN_WIDTH-1:0]     y_prev,
   input  logic signed [ANGLE_WIDTH-1:0]  z_prev,
   output ctl_type                        ctl_ff,
   output logic signed [CORDIC_WIDTH-1:0] x_ff,
   output logic signed [CORDIC_WIDTH-1:0] y_ff,
   output logic signed [ANGLE_WIDTH-1:0]  z_ff
);

   // stage a: shift amount
   logic signed [IN_WIDTH-1:0]    mag_y;
   logic [IN_WIDTH-2:0]           lead_bits;
   logic [SHIFT_WIDTH-1:0]        top_bit;
   logic [SHIFT_WIDTH-1:0]        sha_in;
   ctl_type                       ctla_ff;
   logic signed [IN_WIDTH-1:0]    xa_ff, ya_ff;
   logic signed [ANGLE_WIDTH-1:0] za_ff;
   logic [SHIFT_WIDTH-1:0]        sha_ff;

   // stage b: coarse shift
   logic signed [CORDIC_WIDTH-1:0] x_wide, y_wide;
   logic signed [CORDIC_WIDTH-1:0] xb_in, yb_in;
   ctl_type                        ctlb_ff;
   logic signed [CORDIC_WIDTH-1:0] xb_ff, yb_ff;
   logic signed [ANGLE_WIDTH-1:0]  zb_ff;
   logic [2:0]                     shb_ff;

   always_comb begin
      mag_y     = y_prev[IN_WIDTH-1] ? -y_prev : y_prev;
      lead_bits = x_prev[IN_WIDTH-2:0] | mag_y[IN_WIDTH-2:0];
      top_bit   = '0;
      for (int i = 0; i < IN_WIDTH - 1; i++) begin
         if (lead_bits[i]) begin
            top_bit = SHIFT_WIDTH'(i);
         end
      end
      sha_in = SHIFT_WIDTH'(NORM_TOP) - top_bit;
   end

   always_comb begin
      x_wide = {{(CORDIC_WIDTH-IN_WIDTH){xa_ff[IN_WIDTH-1]}}, xa_ff};
      y_wide = {{(CORDIC_WIDTH-IN_WIDTH){ya_ff[IN_WIDTH-1]}}, ya_ff};
      xb_in  = x_wide <<< {sha_ff[SHIFT_WIDTH-1:3], 3'b000};
      yb_in  = y_wide <<< {sha_ff[SHIFT_WIDTH-1:3], 3'b000};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctla_ff <= '0;
         ctlb_ff <= '0;
         ctl_ff  <= '0;
      end else if (en) begin
         ctla_ff <= ctl_prev;
         ctlb_ff <= ctla_ff;
         ctl_ff  <= ctlb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xa_ff  <= x_prev;
         ya_ff  <= y_prev;
         za_ff  <= z_prev;
         sha_ff <= sha_in;
         xb_ff  <= xb_in;
         yb_ff  <= yb_in;
         zb_ff  <= za_ff;
         shb_ff <= sha_ff[2:0];
         x_ff   <= xb_ff <<< shb_ff;
         y_ff   <= yb_ff <<< shb_ff;
         z_ff   <= zb_ff;
      end
   end

endmodule

@@ rtl/fmpd_cordic_step.sv @@
// ----------------------------------------------------------------------------
// FM phase discriminator CORDIC step
// One registered vectoring iteration: rotate toward y = 0 and accumulate
// the table angle for this step.
// ----------------------------------------------------------------------------
module fmpd_cordic_step
   import fmpd_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  ctl_type                        ctl_prev,
   input  logic signed [CORDIC_WIDTH-1:0] x_prev,
   input  logic signed [CORDIC_WIDTH-1:0] y_prev,
   input  logic signed [ANGLE_WIDTH-1:0]  z_prev,
   output ctl_type                        ctl_ff,
   output logic signed [CORDIC_WIDTH-1:0] x_ff,
   output logic signed [CORDIC_WIDTH-1:0] y_ff,
   output logic signed [ANGLE_WIDTH-1:0]  z_ff
);

   logic signed [CORDIC_WIDTH-1:0] x_in, y_in;
   logic signed [ANGLE_WIDTH-1:0]  z_in;

   always_comb begin
      if (!y_prev[CORDIC_WIDTH-1]) begin
         x_in = x_prev + (y_prev >>> STEP);
         y_in = y_prev - (x_prev >>> STEP);
         z_in = z_prev + ATAN_TABLE[STEP];
      end else begin
         x_in = x_prev - (y_prev >>> STEP);
         y_in = y_prev + (x_prev >>> STEP);
         z_in = z_prev - ATAN_TABLE[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule

@@ rtl/fm_phase_discriminator_top.sv @@
// ----------------------------------------------------------------------------
// FM phase discriminator
// Conjugate product of two complex samples and its angle by a pipelined
// CORDIC, as a signed phase in units of pi/2^(PHASE_WIDTH-1).
//
// Usage:
//  - Request channel req_*: two complex samples and an end-of-buffer flag.
//    Taken on a clock edge with req_valid high and req_stall low.
//  - Response channel rsp_*: phase and the copied flag, one per request,
//    in request order. Taken when rsp_valid is high and rsp_stall low.
//  - Pipeline: 3 product/fold stages, 3 normalize stages, 30 CORDIC stages,
//    round register and output register.
//  - Throughput: one request per cycle while req_stall is low, set by the
//    fully pipelined CORDIC.
//  - A stalled response sits in the output register; a one-entry skid
//    buffer catches the item already leaving the pipeline, and req_stall
//    (a register) holds the whole pipeline while the skid is full.
//  - Reset (synchronous) empties the pipeline; no request is in flight
//    afterwards and the block accepts in the next cycle.
// ----------------------------------------------------------------------------
module fm_phase_discriminator_top
   import fmpd_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int PHASE_WIDTH  = 16
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_first_i,
   input  logic signed [SAMPLE_WIDTH-1:0] req_first_q,
   input  logic signed [SAMPLE_WIDTH-1:0] req_second_i,
   input  logic signed [SAMPLE_WIDTH-1:0] req_second_q,
   input  logic                          req_block_end,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [PHASE_WIDTH-1:0] rsp_phase,
   output logic                          rsp_block_end_out
);

   localparam int PROD_WIDTH  = 2 * SAMPLE_WIDTH;
   localparam int VEC_WIDTH   = 2 * SAMPLE_WIDTH + 1;
   localparam int ROUND_SHIFT = 32 - PHASE_WIDTH;
   localparam logic signed [ANGLE_WIDTH:0] ROUND_BIAS =
      (ANGLE_WIDTH+1)'(1) <<< (ROUND_SHIFT - 1);
   localparam logic signed [ANGLE_WIDTH:0] PH_MAX =
      (ANGLE_WIDTH+1)'((1 <<< (PHASE_WIDTH - 1)) - 1);
   localparam logic signed [ANGLE_WIDTH:0] PH_MIN =
      (ANGLE_WIDTH+1)'(-(1 <<< (PHASE_WIDTH - 1)));

   logic en;

   // stage 1: products
   ctl_type                      s1_ctl_in, s1_ctl_ff;
   logic signed [PROD_WIDTH-1:0] ac_ff, bd_ff, bc_ff, ad_ff;

   // stage 2: conjugate product
   ctl_type                     s2_ctl_ff;
   logic signed [VEC_WIDTH-1:0] re_in, im_in, re_ff, im_ff;

   // stage 3: quadrant fold
   ctl_type                       s3_ctl_in, s3_ctl_ff;
   logic signed [VEC_WIDTH-1:0]   fx_in, fy_in, fx_ff, fy_ff;
   logic signed [ANGLE_WIDTH-1:0] fz_in, fz_ff;

   // CORDIC chain
   ctl_type                        c_ctl [CORDIC_STEPS+1];
   logic signed [CORDIC_WIDTH-1:0] c_x   [CORDIC_STEPS+1];
   logic signed [CORDIC_WIDTH-1:0] c_y   [CORDIC_STEPS+1];
   logic signed [ANGLE_WIDTH-1:0]  c_z   [CORDIC_STEPS+1];

   // round and clamp
   logic signed [ANGLE_WIDTH:0]  rounded, scaled;
   logic signed [PHASE_WIDTH-1:0] r_phase_in, r_phase_ff;
   ctl_type                       r_ctl_ff;

   // output register and skid
   logic                          out_take, out_load;
   logic                          out_valid_in, out_valid_ff;
   logic signed [PHASE_WIDTH-1:0] out_phase_ff;
   logic                          out_last_ff;
   logic                          skid_valid_in, skid_valid_ff;
   logic signed [PHASE_WIDTH-1:0] skid_phase_ff;
   logic                          skid_last_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign s1_ctl_in = '{valid: req_valid, last: req_block_end, zero: 1'b0};

   assign re_in = {ac_ff[PROD_WIDTH-1], ac_ff} + {bd_ff[PROD_WIDTH-1], bd_ff};
   assign im_in = {bc_ff[PROD_WIDTH-1], bc_ff} - {ad_ff[PROD_WIDTH-1], ad_ff};

   always_comb begin
      s3_ctl_in      = s2_ctl_ff;
      s3_ctl_in.zero = (re_ff == '0) && (im_ff == '0);
      if (re_ff[VEC_WIDTH-1]) begin
         if (!im_ff[VEC_WIDTH-1]) begin
            fx_in = im_ff;
            fy_in = -re_ff;
            fz_in = ANGLE_QUARTER;
         end else begin
            fx_in = -im_ff;
            fy_in = re_ff;
            fz_in = -ANGLE_QUARTER;
         end
      end else begin
         fx_in = re_ff;
         fy_in = im_ff;
         fz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else if (en) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s3_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ac_ff <= PROD_WIDTH'(req_first_i) * PROD_WIDTH'(req_second_i);
         bd_ff <= PROD_WIDTH'(req_first_q) * PROD_WIDTH'(req_second_q);
         bc_ff <= PROD_WIDTH'(req_first_q) * PROD_WIDTH'(req_second_i);
         ad_ff <= PROD_WIDTH'(req_first_i) * PROD_WIDTH'(req_second_q);
         re_ff <= re_in;
         im_ff <= im_in;
         fx_ff <= fx_in;
         fy_ff <= fy_in;
         fz_ff <= fz_in;
      end
   end

   fmpd_norm #(
      .IN_WIDTH (VEC_WIDTH)
   ) u_norm (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_prev (s3_ctl_ff),
      .x_prev   (fx_ff),
      .y_prev   (fy_ff),
      .z_prev   (fz_ff),
      .ctl_ff   (c_ctl[0]),
      .x_ff     (c_x[0]),
      .y_ff     (c_y[0]),
      .z_ff     (c_z[0])
   );

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      fmpd_cordic_step #(
         .STEP (k)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctl_prev (c_ctl[k]),
         .x_prev   (c_x[k]),
         .y_prev   (c_y[k]),
         .z_prev   (c_z[k]),
         .ctl_ff   (c_ctl[k+1]),
         .x_ff     (c_x[k+1]),
         .y_ff     (c_y[k+1]),
         .z_ff     (c_z[k+1])
      );
   end

   // round half up, clamp; +pi lands on the positive limit
   always_comb begin
      rounded = {c_z[CORDIC_STEPS][ANGLE_WIDTH-1], c_z[CORDIC_STEPS]} + ROUND_BIAS;
      scaled  = rounded >>> ROUND_SHIFT;
      if (c_ctl[CORDIC_STEPS].zero) begin
         r_phase_in = '0;
      end else if (scaled > PH_MAX) begin
         r_phase_in = PH_MAX[PHASE_WIDTH-1:0];
      end else if (scaled < PH_MIN) begin
         r_phase_in = PH_MIN[PHASE_WIDTH-1:0];
      end else begin
         r_phase_in = scaled[PHASE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ctl_ff <= '0;
      end else if (en) begin
         r_ctl_ff <= c_ctl[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_phase_ff <= r_phase_in;
      end
   end

   // output register with one-entry skid
   always_comb begin
      out_take = out_valid_ff && !rsp_stall;
      if (skid_valid_ff) begin
         out_load      = out_take;
         out_valid_in  = 1'b1;
         skid_valid_in = !out_take;
      end else begin
         out_load      = !out_valid_ff || out_take;
         out_valid_in  = out_load ? r_ctl_ff.valid : out_valid_ff;
         skid_valid_in = r_ctl_ff.valid && out_valid_ff && !out_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_phase_ff <= skid_valid_ff ? skid_phase_ff : r_phase_ff;
         out_last_ff  <= skid_valid_ff ? skid_last_ff : r_ctl_ff.last;
      end
      if (!skid_valid_ff) begin
         skid_phase_ff <= r_phase_ff;
         skid_last_ff  <= r_ctl_ff.last;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_phase         = out_phase_ff;
   assign rsp_block_end_out = out_last_ff;

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a response while the output register is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid filled without a stalled response");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> out_valid_ff)
      else $error("skid response lost on drain");
`endif

endmodule
